>>> hdl/lattice_matrix_canonical_check_unit_defines.svh
// Assertion macros shared by the canonical check RTL.
`ifndef LATTICE_MATRIX_CANONICAL_CHECK_UNIT_DEFINES_SVH
`define LATTICE_MATRIX_CANONICAL_CHECK_UNIT_DEFINES_SVH

// Same-cycle implication on clk, disabled while rst_n is asserted.
`define LMCC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication on clk, disabled while rst_n is asserted.
`define LMCC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/lmcc_pkg.sv
// Types, codes and matrix arithmetic for the lattice canonical check unit.
`timescale 1ns / 1ps
`default_nettype none

package lmcc_pkg;

    localparam int NUM_ELEM = 9;
    localparam int ELEM_W   = 4;
    localparam int MAT_W    = NUM_ELEM * ELEM_W;
    localparam int TMP_W    = 9;   // |C*M| elements stay within +-192
    localparam int IMG_W    = 14;  // |C*M*P| elements stay within +-4608
    localparam int WIT_W    = 6;
    localparam int RANGE_W  = 3;
    localparam int COUNT_W  = 6;
    localparam int CFG_IDX_W = 2;

    typedef logic signed [ELEM_W-1:0] elem_t;
    typedef logic signed [TMP_W-1:0]  tmp_t;
    typedef logic signed [IMG_W-1:0]  img_t;

    // Matrices are column-major: element (row, col) at col*3+row
    typedef elem_t mat_t [NUM_ELEM];
    typedef tmp_t  tmat_t [NUM_ELEM];
    typedef img_t  imat_t [NUM_ELEM];

    typedef enum logic [1:0] {
        ACT_LOAD_PARENT = 2'd0,
        ACT_LOAD_CHILD  = 2'd1,
        ACT_CHECK       = 2'd2
    } action_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SEARCH_RANGE = 2'd0,
        CFG_PARENT_COUNT = 2'd1,
        CFG_CHILD_COUNT  = 2'd2
    } cfg_reg_t;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_RUN  = 3'b010,
        ST_EMIT = 3'b100
    } state_t;

    // Table word layout: element k at bits [4k+3:4k]
    function automatic mat_t unpack_mat(input logic [MAT_W-1:0] w);
        mat_t m;
        for (int k = 0; k < NUM_ELEM; k++)
        begin
            m[k] = w[k*ELEM_W +: ELEM_W];
        end
        return m;
    endfunction

    // First product: child op times candidate
    function automatic tmat_t mul_small(input mat_t a, input mat_t b);
        tmat_t r;
        tmp_t  s;
        for (int col = 0; col < 3; col++)
        begin
            for (int row = 0; row < 3; row++)
            begin
                s = '0;
                for (int k = 0; k < 3; k++)
                begin
                    s = s + tmp_t'(a[k*3+row]) * tmp_t'(b[col*3+k]);
                end
                r[col*3+row] = s;
            end
        end
        return r;
    endfunction

    // Second product: partial image times parent op
    function automatic imat_t mul_wide(input tmat_t a, input mat_t b);
        imat_t r;
        img_t  s;
        for (int col = 0; col < 3; col++)
        begin
            for (int row = 0; row < 3; row++)
            begin
                s = '0;
                for (int k = 0; k < 3; k++)
                begin
                    s = s + img_t'(a[k*3+row]) * img_t'(b[col*3+k]);
                end
                r[col*3+row] = s;
            end
        end
        return r;
    endfunction

    // All elements within +-lim
    function automatic logic in_range(input imat_t m, input logic [RANGE_W-1:0] lim);
        img_t hi;
        img_t lo;
        logic ok;
        hi = img_t'({1'b0, lim});
        lo = -hi;
        ok = 1'b1;
        for (int k = 0; k < NUM_ELEM; k++)
        begin
            if (m[k] > hi || m[k] < lo)
            begin
                ok = 1'b0;
            end
        end
        return ok;
    endfunction

    // Lexicographic compare in column-major order; first differing element decides
    function automatic logic lex_less(input imat_t a, input mat_t b);
        logic decided;
        logic less;
        decided = 1'b0;
        less    = 1'b0;
        for (int k = 0; k < NUM_ELEM; k++)
        begin
            if (!decided && a[k] != img_t'(b[k]))
            begin
                decided = 1'b1;
                less    = (a[k] < img_t'(b[k]));
            end
        end
        return less;
    endfunction

endpackage

`default_nettype wire

>>> hdl/lattice_matrix_canonical_check_unit.sv
// Canonical-representative check of a 3x3 integer lattice matrix under two op tables.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+------------------------------------------
//  in      | to block  | in_valid/in_stall  | action, slot, elem_r0c0 .. elem_r2c2
//  out     | from block| out_valid/out_stall| is_canonical, witness_parent, witness_child
//  cfg     | to block  | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// A load request is one write into the parent or child table.
// A check request walks pairs at one per cycle through the table read ports,
// then drains the pipeline and hands off the result; it ends early when a smaller
// image turns up, and waits while the output register is still held by a stalled
// result. in_stall stays high while a check runs.
// Reset clears control and configuration registers only; the op tables hold garbage until loaded.
// A finished result waits in the output register while new requests are taken.
`timescale 1ns / 1ps
`default_nettype none
`include "lattice_matrix_canonical_check_unit_defines.svh"

module lattice_matrix_canonical_check_unit #(
    parameter int MAX_OPS = 48
) (
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [1:0]  action,
    input  wire logic [5:0]  slot,
    input  wire logic [3:0]  elem_r0c0,
    input  wire logic [3:0]  elem_r1c0,
    input  wire logic [3:0]  elem_r2c0,
    input  wire logic [3:0]  elem_r0c1,
    input  wire logic [3:0]  elem_r1c1,
    input  wire logic [3:0]  elem_r2c1,
    input  wire logic [3:0]  elem_r0c2,
    input  wire logic [3:0]  elem_r1c2,
    input  wire logic [3:0]  elem_r2c2,

    output logic             out_valid,
    input  wire logic        out_stall,
    output logic             is_canonical,
    output logic [5:0]       witness_parent,
    output logic [5:0]       witness_child,

    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [31:0] cfg_data
);

    localparam int IDX_W = (MAX_OPS > 1) ? $clog2(MAX_OPS) : 1;
    localparam int CNT_W = $clog2(MAX_OPS + 1);

    // ---------------------------------------------------------------- config
    logic [lmcc_pkg::RANGE_W-1:0] range_reg;
    logic [lmcc_pkg::COUNT_W-1:0] pcount_reg;
    logic [lmcc_pkg::COUNT_W-1:0] ccount_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            range_reg  <= 3'd1;
            pcount_reg <= 6'd1;
            ccount_reg <= 6'd1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                lmcc_pkg::CFG_SEARCH_RANGE: range_reg  <= cfg_data[lmcc_pkg::RANGE_W-1:0];
                lmcc_pkg::CFG_PARENT_COUNT: pcount_reg <= cfg_data[lmcc_pkg::COUNT_W-1:0];
                lmcc_pkg::CFG_CHILD_COUNT:  ccount_reg <= cfg_data[lmcc_pkg::COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    // Counts saturate at table depth
    logic [CNT_W-1:0] np;
    logic [CNT_W-1:0] nc;
    assign np = (7'(pcount_reg) > 7'(MAX_OPS)) ? CNT_W'(MAX_OPS) : CNT_W'(pcount_reg);
    assign nc = (7'(ccount_reg) > 7'(MAX_OPS)) ? CNT_W'(MAX_OPS) : CNT_W'(ccount_reg);

    // ---------------------------------------------------------------- input decode
    lmcc_pkg::state_t state_reg;
    lmcc_pkg::state_t state_next;

    logic in_acc;
    logic is_check;
    logic slot_ok;
    logic [lmcc_pkg::MAT_W-1:0] in_word;

    assign in_stall = (state_reg != lmcc_pkg::ST_IDLE);
    assign in_acc   = in_valid && !in_stall;
    assign is_check = (action == lmcc_pkg::ACT_CHECK);
    assign slot_ok  = (7'(slot) < 7'(MAX_OPS));
    assign in_word  = {elem_r2c2, elem_r1c2, elem_r0c2,
                       elem_r2c1, elem_r1c1, elem_r0c1,
                       elem_r2c0, elem_r1c0, elem_r0c0};

    // Candidate latched at check start
    logic [lmcc_pkg::MAT_W-1:0] cand_reg;
    lmcc_pkg::mat_t cand;
    assign cand = lmcc_pkg::unpack_mat(cand_reg);

    always_ff @(posedge clk)
    begin
        if (in_acc && is_check)
        begin
            cand_reg <= in_word;
        end
    end

    // ---------------------------------------------------------------- op tables
    logic [lmcc_pkg::MAT_W-1:0] parent_mem [MAX_OPS];
    logic [lmcc_pkg::MAT_W-1:0] child_mem  [MAX_OPS];
    logic [lmcc_pkg::MAT_W-1:0] prd_reg;
    logic [lmcc_pkg::MAT_W-1:0] crd_reg;

    logic [CNT_W-1:0] i_reg;
    logic [CNT_W-1:0] i_next;
    logic [CNT_W-1:0] j_reg;
    logic [CNT_W-1:0] j_next;

    always_ff @(posedge clk)
    begin
        if (in_acc && slot_ok && action == lmcc_pkg::ACT_LOAD_PARENT)
        begin
            parent_mem[slot[IDX_W-1:0]] <= in_word;
        end
        prd_reg <= parent_mem[i_reg[IDX_W-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (in_acc && slot_ok && action == lmcc_pkg::ACT_LOAD_CHILD)
        begin
            child_mem[slot[IDX_W-1:0]] <= in_word;
        end
        crd_reg <= child_mem[j_reg[IDX_W-1:0]];
    end

    // ---------------------------------------------------------------- pair sequencer
    logic can_issue;
    logic issuing;
    logic hit;
    logic s1_valid_reg;
    logic s2_valid_reg;
    logic s3_valid_reg;
    logic drained;

    assign can_issue = (i_reg < np) && (j_reg < nc);
    assign issuing   = (state_reg == lmcc_pkg::ST_RUN) && can_issue && !hit;
    assign drained   = !can_issue && !s1_valid_reg && !s2_valid_reg && !s3_valid_reg;

    always_comb
    begin
        i_next = i_reg;
        j_next = j_reg;
        if (in_acc && is_check)
        begin
            // pair (0,0) is the identity pair and is skipped
            if (nc > CNT_W'(1))
            begin
                i_next = '0;
                j_next = CNT_W'(1);
            end
            else
            begin
                i_next = CNT_W'(1);
                j_next = '0;
            end
        end
        else if (issuing)
        begin
            if (({1'b0, j_reg} + 1'b1) == {1'b0, nc})
            begin
                j_next = '0;
                i_next = i_reg + 1'b1;
            end
            else
            begin
                j_next = j_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            i_reg <= '0;
            j_reg <= '0;
        end
        else
        begin
            i_reg <= i_next;
            j_reg <= j_next;
        end
    end

    // ---------------------------------------------------------------- image pipeline
    // s1: table words read; s2: child*cand; s3: full image
    logic [IDX_W-1:0] s1_i_reg;
    logic [IDX_W-1:0] s1_j_reg;
    logic [IDX_W-1:0] s2_i_reg;
    logic [IDX_W-1:0] s2_j_reg;
    logic [IDX_W-1:0] s3_i_reg;
    logic [IDX_W-1:0] s3_j_reg;
    lmcc_pkg::tmat_t  tmp_reg;
    lmcc_pkg::mat_t   p_reg;
    lmcc_pkg::imat_t  img_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else if (hit)
        begin
            // later pairs in flight are dropped
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= issuing;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_i_reg <= i_reg[IDX_W-1:0];
        s1_j_reg <= j_reg[IDX_W-1:0];
        s2_i_reg <= s1_i_reg;
        s2_j_reg <= s1_j_reg;
        s3_i_reg <= s2_i_reg;
        s3_j_reg <= s2_j_reg;
        tmp_reg  <= lmcc_pkg::mul_small(lmcc_pkg::unpack_mat(crd_reg), cand);
        p_reg    <= lmcc_pkg::unpack_mat(prd_reg);
        img_reg  <= lmcc_pkg::mul_wide(tmp_reg, p_reg);
    end

    // Image test: in range and smaller than candidate
    assign hit = s3_valid_reg
              && lmcc_pkg::in_range(img_reg, range_reg)
              && lmcc_pkg::lex_less(img_reg, cand);

    // ---------------------------------------------------------------- control
    logic out_free;
    logic res_canon_reg;
    logic [IDX_W-1:0] res_par_reg;
    logic [IDX_W-1:0] res_chd_reg;

    assign out_free = !out_valid || !out_stall;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            lmcc_pkg::ST_IDLE:
            begin
                if (in_acc && is_check)
                begin
                    state_next = lmcc_pkg::ST_RUN;
                end
            end
            lmcc_pkg::ST_RUN:
            begin
                if (hit || drained)
                begin
                    state_next = lmcc_pkg::ST_EMIT;
                end
            end
            lmcc_pkg::ST_EMIT:
            begin
                if (out_free)
                begin
                    state_next = lmcc_pkg::ST_IDLE;
                end
            end
            default: state_next = lmcc_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lmcc_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Result held until the output register is free
    always_ff @(posedge clk)
    begin
        if (state_reg == lmcc_pkg::ST_RUN && (hit || drained))
        begin
            res_canon_reg <= !hit;
            res_par_reg   <= hit ? s3_i_reg : '0;
            res_chd_reg   <= hit ? s3_j_reg : '0;
        end
    end

    // ---------------------------------------------------------------- output register
    logic out_valid_reg;
    logic out_valid_next;
    logic load_out;

    assign load_out = (state_reg == lmcc_pkg::ST_EMIT) && out_free;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            is_canonical   <= res_canon_reg;
            witness_parent <= lmcc_pkg::WIT_W'(res_par_reg);
            witness_child  <= lmcc_pkg::WIT_W'(res_chd_reg);
        end
    end

    assign out_valid = out_valid_reg;

    // ---------------------------------------------------------------- assertions
    logic in_run;
    logic in_emit;
    logic pipe_busy;
    logic witness_zero;

    assign in_run       = (state_reg == lmcc_pkg::ST_RUN);
    assign in_emit      = (state_reg == lmcc_pkg::ST_EMIT);
    assign pipe_busy    = s1_valid_reg || s2_valid_reg || s3_valid_reg;
    assign witness_zero = (witness_parent == '0) && (witness_child == '0);

    `LMCC_ASSERT_NEXT(a_hit_emits, in_run && hit, in_emit && !s3_valid_reg, "hit kept running")
    `LMCC_ASSERT_NOW(a_out_from_emit, $rose(out_valid_reg), $past(in_emit), "stray result")
    `LMCC_ASSERT_NOW(a_pipe_in_run, pipe_busy, in_run, "pair in flight outside a check")
    `LMCC_ASSERT_NOW(a_wit_nonzero, out_valid && !is_canonical, !witness_zero, "identity witness")

endmodule

`default_nettype wire
